FILE: sv/gdad_pkg.sv
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and calendar helpers for the date add-days core.
// ----------------------------------------------------------------------------
package gdad_pkg;

    // Calendar constants
    localparam int unsigned MONTHS_PER_YEAR = 12;
    localparam int unsigned FEB_DAYS        = 28;
    localparam int unsigned CENTURY_YEARS   = 100;
    localparam int unsigned LEAP_CYCLE      = 400;

    // Width of the year-modulo-400 residue
    localparam int unsigned M400_W = 9;

    // Month codes used by the sequencer
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_ROLL,
        ST_DONE
    } t_state;

    // Length of a month in days; leap selects the 29-day February
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                 len = leap ? 5'(FEB_DAYS + 1) : 5'(FEB_DAYS);
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:              len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: sv/gdad_if.sv
// ----------------------------------------------------------------------------
// gdad_if
// Valid/ready channels for the date add-days core: request and result.
// ----------------------------------------------------------------------------
interface gdad_in_if #(
    parameter int unsigned YEAR_BITS = 16,
    parameter int unsigned DAYS_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [4:0]           start_day;
    logic [3:0]           start_month;
    logic [YEAR_BITS-1:0] start_year;
    logic [DAYS_BITS-1:0] days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface gdad_out_if #(
    parameter int unsigned YEAR_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [4:0]           result_day;
    logic [3:0]           result_month;
    logic [YEAR_BITS-1:0] result_year;
    logic                 year_overflow;

    modport source (output valid, result_day, result_month, result_year, year_overflow,
                    input ready);
    modport sink   (input valid, result_day, result_month, result_year, year_overflow,
                    output ready);
endinterface

FILE: sv/gregorian_date_add_days_core.sv
// Sequence: ST_MOD takes the start year modulo 400, ST_ROLL rolls the months one
//   at a time and ends on a final compare, and the result is then held in ST_DONE.
// Throughput: one transaction at a time; a new request is taken no earlier than the
//   cycle after the result has been handed off.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle, no result.
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core
// Adds a day count to a Gregorian date by rolling one month per cycle through
// a single shared compare/subtract unit.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_core #(
    parameter int unsigned YEAR_BITS = 16,
    parameter int unsigned DAYS_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdad_in_if.sink   i_in,
    gdad_out_if.source o_out
);

    localparam int unsigned DW    = DAYS_BITS + 1;
    localparam int unsigned UW    = (DW > 10) ? DW : 10;
    localparam int unsigned MW    = gdad_pkg::M400_W;

    // Reciprocal of 100 for a 32-bit dividend: q = (y * RECIP_100) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_100   = 32'h51EB851F;
    localparam int unsigned RECIP_SHIFT = 37;
    localparam int unsigned QW          = 64 - RECIP_SHIFT;

    gdad_pkg::t_state r_state, n_state;
    logic [DW-1:0]        r_day,   n_day;
    logic [3:0]           r_month, n_month;
    logic [YEAR_BITS-1:0] r_year,  n_year;
    logic [QW-1:0]        r_q100,  n_q100;
    logic [MW-1:0]        r_m400,  n_m400;
    logic                 r_ovf,   n_ovf;

    // Shared compare/subtract unit
    logic [UW-1:0] s_a, s_b;
    logic [UW:0]   s_diff;
    logic          s_borrow;
    logic          s_leap;
    logic [4:0]    s_mlen;
    logic [DW-1:0] s_start_day;
    logic [YEAR_BITS-1:0] s_year_inc;
    logic [MW-1:0] s_m400_inc;

    // Year modulo 400 from the quotient by 100
    logic [31:0] s_year32;
    logic [63:0] s_prod;
    logic [31:0] s_q4;
    logic [31:0] s_c400;
    logic [31:0] s_yrem;

    assign s_diff   = {1'b0, s_a} - {1'b0, s_b};
    assign s_borrow = s_diff[UW];

    // Leap year: divisible by 4, and not a century unless divisible by 400
    assign s_leap = (r_year[1:0] == 2'b00) &&
                    !(r_m400 inside {MW'(gdad_pkg::CENTURY_YEARS),
                                     MW'(2 * gdad_pkg::CENTURY_YEARS),
                                     MW'(3 * gdad_pkg::CENTURY_YEARS)});
    assign s_mlen = gdad_pkg::month_len(r_month, s_leap);

    assign s_start_day = (i_in.start_day == 5'd0) ? DW'(1) : DW'(i_in.start_day);
    assign s_year_inc  = r_year + YEAR_BITS'(1);
    assign s_m400_inc  = (r_m400 == MW'(gdad_pkg::LEAP_CYCLE - 1)) ? '0
                                                                   : r_m400 + MW'(1);

    // Quotient by 100 of the incoming year; clear its low two bits to get 4 * (y / 400)
    assign s_year32 = 32'(i_in.start_year);
    assign s_prod   = 64'(s_year32) * 64'(RECIP_100);
    assign s_q4     = 32'({r_q100[QW-1:2], 2'b00});
    assign s_c400   = (s_q4 << 6) + (s_q4 << 5) + (s_q4 << 2);
    assign s_yrem   = 32'(r_year) - s_c400;

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdad_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the working registers
    always_ff @(posedge i_clk) begin
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        r_q100  <= n_q100;
        r_m400  <= n_m400;
        r_ovf   <= n_ovf;
    end

    // Advance the sequencer and drive the shared unit
    always_comb begin
        n_state = r_state;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_q100  = r_q100;
        n_m400  = r_m400;
        n_ovf   = r_ovf;
        s_a     = '0;
        s_b     = '0;

        case (r_state)
            gdad_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_day   = s_start_day + DW'(i_in.days_to_add);
                    n_month = (i_in.start_month < gdad_pkg::MONTH_JAN ||
                               i_in.start_month > gdad_pkg::MONTH_DEC)
                              ? gdad_pkg::MONTH_JAN : i_in.start_month;
                    n_year  = i_in.start_year;
                    n_q100  = s_prod[63:RECIP_SHIFT];
                    n_ovf   = 1'b0;
                    n_state = gdad_pkg::ST_MOD;
                end
            end

            // Take the year modulo 400 from the registered quotient
            gdad_pkg::ST_MOD: begin
                n_m400  = s_yrem[MW-1:0];
                n_state = gdad_pkg::ST_ROLL;
            end

            // Roll one month while the day exceeds its length
            gdad_pkg::ST_ROLL: begin
                s_a = UW'(r_day);
                s_b = UW'(s_mlen);
                if (!s_borrow && (s_diff != '0)) begin
                    n_day = s_diff[DW-1:0];
                    if (r_month == gdad_pkg::MONTH_DEC) begin
                        n_month = gdad_pkg::MONTH_JAN;
                        n_year  = s_year_inc;
                        if (s_year_inc == '0) begin
                            n_m400 = '0;
                            n_ovf  = 1'b1;
                        end else begin
                            n_m400 = s_m400_inc;
                        end
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end else begin
                    n_state = gdad_pkg::ST_DONE;
                end
            end

            // Hold the result until it is taken
            gdad_pkg::ST_DONE: begin
                if (o_out.ready) begin
                    n_state = gdad_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gdad_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_in.ready          = (r_state == gdad_pkg::ST_IDLE);
    assign o_out.valid         = (r_state == gdad_pkg::ST_DONE);
    assign o_out.result_day    = r_day[4:0];
    assign o_out.result_month  = r_month;
    assign o_out.result_year   = r_year;
    assign o_out.year_overflow = r_ovf;

endmodule
